### hdl/bqlp_pkg.sv
`timescale 1ns / 1ps

package bqlp_pkg;

    localparam int CHANNELS       = 6;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 3;
    localparam int NUM_COEFS      = 5;

    // stream payload, padded to whole bytes
    localparam int DATA_BITS = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

    // one channel enters the datapath per slot; at least four slots per item
    // so a channel's write-back lands before its next read
    localparam int SLOTS     = (CHANNELS > 4) ? CHANNELS : 4;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int Q_BITS    = ACC_BITS + 1 - COEF_FRAC_BITS;

    localparam int CFG_IDX_BITS = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] IDX_B0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] IDX_B1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] IDX_B2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] IDX_A1 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] IDX_A2 = CFG_IDX_BITS'(4);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    localparam logic signed [ACC_BITS:0] RND_HALF = (ACC_BITS + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [Q_BITS-1:0] SAT_MAX  = Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_BITS-1:0] SAT_MIN  = Q_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // per-channel history entry
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } hist_t;

    // round to nearest (ties up), then clamp to the sample range
    function automatic sample_t round_sat(input logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS:0] t;
        logic signed [Q_BITS-1:0] q;
        logic signed [Q_BITS-1:0] r;
        t = $signed({acc[ACC_BITS-1], acc}) + RND_HALF;
        q = $signed(t[ACC_BITS:COEF_FRAC_BITS]);
        if (q > SAT_MAX) begin
            r = SAT_MAX;
        end else if (q < SAT_MIN) begin
            r = SAT_MIN;
        end else begin
            r = q;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

endpackage

### hdl/biquad_lowpass_multichannel.sv
`timescale 1ns / 1ps

// Throughput: a new beat is taken on the last slot of the previous one if fewer than
//   two beats are in flight; while a beat is sequenced, one channel enters the
//   multiply/accumulate pipeline per cycle through the single history-RAM read port.
// Reset: aresetn is synchronous, active low; coefficients return to b0 = 1.0 and the
//   rest 0, and the first beat after reset primes all history of each channel.
module biquad_lowpass_multichannel (
    input  logic                                      aclk,
    input  logic                                      aresetn,

    // coefficient write port
    input  logic                                      cfg_wr_en,
    input  logic [bqlp_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [bqlp_pkg::COEF_BITS-1:0]            cfg_data,

    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [bqlp_pkg::DATA_BITS-1:0]            s_tdata,  // sample_0 .. sample_5

    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [bqlp_pkg::DATA_BITS-1:0]            m_tdata   // filtered_0 .. filtered_5
);

    import bqlp_pkg::*;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);
    localparam logic [SLOT_BITS-1:0] SLOT_CHS  = SLOT_BITS'(CHANNELS);
    localparam logic [CH_BITS-1:0]   CH_LAST   = CH_BITS'(CHANNELS - 1);

    // coefficient registers
    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    // input beat holding and channel sequencer
    sample_t                samp_reg [CHANNELS];
    logic                   item_prime_reg;
    logic                   primed_reg;
    logic                   busy_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [1:0]             inflight_reg;

    logic                   s_fire;
    logic                   m_fire;
    logic                   s0_valid;
    logic [CH_BITS-1:0]     rd_ch;

    // history RAM: one entry per channel, read-modify-write
    hist_t                  hist_mem [CHANNELS];
    hist_t                  hist_rd_reg;

    // stage 1: RAM data arrives
    logic                   s1_valid_reg;
    logic [CH_BITS-1:0]     s1_ch_reg;
    sample_t                s1_x_reg;
    logic                   s1_prime_reg;
    hist_t                  s1_hist;

    // stage 2: products
    logic                   s2_valid_reg;
    logic [CH_BITS-1:0]     s2_ch_reg;
    sample_t                s2_x_reg, s2_x1_reg, s2_y1_reg;
    logic signed [PROD_BITS-1:0] pb0_reg, pb1_reg, pb2_reg, pa1_reg, pa2_reg;

    // stage 3: partial sums, then round, saturate and write back
    logic                   s3_valid_reg;
    logic [CH_BITS-1:0]     s3_ch_reg;
    sample_t                s3_x_reg, s3_x1_reg, s3_y1_reg;
    logic signed [ACC_BITS-1:0] ff_reg, fb_reg;
    sample_t                s3_y;
    hist_t                  wr_hist;

    // result collection and output register
    sample_t                col_reg [CHANNELS];
    logic                   col_full_reg;
    logic                   xfer;
    sample_t                out_reg [CHANNELS];
    logic                   m_tvalid_reg;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid_reg && m_tready;

    // take a new beat on the last slot of the previous one; cap at two beats
    // between input and output so the collection buffer never overruns
    assign s_tready = (!busy_reg || (slot_reg == SLOT_LAST)) && (inflight_reg < 2'd2);

    assign s0_valid = busy_reg && (slot_reg < SLOT_CHS);
    assign rd_ch    = slot_reg[CH_BITS-1:0];

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= COEF_ONE;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                IDX_B0:  b0_reg <= cfg_data;
                IDX_B1:  b1_reg <= cfg_data;
                IDX_B2:  b2_reg <= cfg_data;
                IDX_A1:  a1_reg <= cfg_data;
                IDX_A2:  a2_reg <= cfg_data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            slot_reg     <= '0;
            primed_reg   <= 1'b0;
            inflight_reg <= '0;
        end else begin
            if (s_fire) begin
                busy_reg   <= 1'b1;
                slot_reg   <= '0;
                primed_reg <= 1'b1;
            end else if (busy_reg) begin
                if (slot_reg == SLOT_LAST) begin
                    busy_reg <= 1'b0;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            case ({s_fire, m_fire})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // hold the beat's samples for the sequencer; flag the first beat after reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int c = 0; c < CHANNELS; c++) begin
                samp_reg[c] <= s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
            end
            item_prime_reg <= !primed_reg;
        end
    end

    // ---------------------------------------------------------- history RAM
    always_ff @(posedge aclk) begin
        hist_rd_reg <= hist_mem[rd_ch];
        if (s3_valid_reg) begin
            hist_mem[s3_ch_reg] <= wr_hist;
        end
    end

    // -------------------------------------------------------------- stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s0_valid;
        end
        s1_ch_reg    <= rd_ch;
        s1_x_reg     <= samp_reg[rd_ch];
        s1_prime_reg <= item_prime_reg;
    end

    // on the priming beat every history slot takes the current sample
    always_comb begin
        if (s1_prime_reg) begin
            s1_hist = '{x1: s1_x_reg, x2: s1_x_reg, y1: s1_x_reg, y2: s1_x_reg};
        end else begin
            s1_hist = hist_rd_reg;
        end
    end

    // -------------------------------------------------------------- stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_ch_reg <= s1_ch_reg;
        s2_x_reg  <= s1_x_reg;
        s2_x1_reg <= s1_hist.x1;
        s2_y1_reg <= s1_hist.y1;
        pb0_reg   <= b0_reg * s1_x_reg;
        pb1_reg   <= b1_reg * s1_hist.x1;
        pb2_reg   <= b2_reg * s1_hist.x2;
        pa1_reg   <= a1_reg * s1_hist.y1;
        pa2_reg   <= a2_reg * s1_hist.y2;
    end

    // -------------------------------------------------------------- stage 3
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
        s3_ch_reg <= s2_ch_reg;
        s3_x_reg  <= s2_x_reg;
        s3_x1_reg <= s2_x1_reg;
        s3_y1_reg <= s2_y1_reg;
        ff_reg    <= ACC_BITS'(pb0_reg) + ACC_BITS'(pb1_reg) + ACC_BITS'(pb2_reg);
        fb_reg    <= ACC_BITS'(pa1_reg) + ACC_BITS'(pa2_reg);
    end

    // the saturated output is what enters the history
    always_comb begin
        s3_y    = round_sat(ff_reg - fb_reg);
        wr_hist = '{x1: s3_x_reg, x2: s3_x1_reg, y1: s3_y, y2: s3_y1_reg};
    end

    // ------------------------------------------------------ collect / output
    assign xfer = col_full_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_full_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s3_valid_reg && (s3_ch_reg == CH_LAST)) begin
                col_full_reg <= 1'b1;
            end else if (xfer) begin
                col_full_reg <= 1'b0;
            end
            if (xfer) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid_reg) begin
            col_reg[s3_ch_reg] <= s3_y;
        end
        if (xfer) begin
            out_reg <= col_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            m_tdata[c*SAMPLE_BITS +: SAMPLE_BITS] = out_reg[c];
        end
    end

    // ------------------------------------------------------------ assertions
    a_inflight_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 2'd2)
        else $error("more than two beats in flight");

    a_no_ram_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s0_valid && s3_valid_reg) |-> (rd_ch != s3_ch_reg))
        else $error("history read and write-back hit the same channel");

    a_col_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_full_reg && m_tvalid_reg && !m_tready) |-> !s3_valid_reg)
        else $error("result written while collection buffer waits");

    a_out_follows_col: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(col_full_reg))
        else $error("output beat raised without a collected result");

endmodule

### test/tb_biquad_lowpass_multichannel.sv
`timescale 1ns / 1ps

module tb_biquad_lowpass_multichannel;

    import bqlp_pkg::*;

    localparam int  LATENCY        = CHANNELS + 4;
    localparam int  SAMPLE_MAX_I   = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int  SAMPLE_MIN_I   = -(2 ** (SAMPLE_BITS - 1));
    localparam int  COEF_MAX_I     = 2 ** (COEF_BITS - 1) - 1;
    localparam int  COEF_MIN_I     = -(2 ** (COEF_BITS - 1));
    localparam int  COEF_ONE_I     = 2 ** COEF_FRAC_BITS;
    localparam int  PHASE_BEATS    = 130;
    localparam int  NUM_PHASES     = 8;
    localparam int  STALL_AT_BEAT  = 250;   // output beat count that triggers the long stall
    localparam int  STALL_CYCLES   = 400;
    localparam int  TIMEOUT_NS     = 5_000_000;

    // coefficient sets used by the random phases
    typedef enum int {
        SET_IDENTITY,
        SET_BUTTER,
        SET_RANDOM_WIDE,
        SET_RANDOM_MILD,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_MIXED
    } coef_set_e;

    // Track the filter state and queue the expected output beats.
    class filter_tracker;
        longint                 coef[NUM_COEFS];
        longint                 x1[CHANNELS];
        longint                 x2[CHANNELS];
        longint                 y1[CHANNELS];
        longint                 y2[CHANNELS];
        bit                     primed;
        logic [DATA_BITS-1:0]   filtered_q[$];
        int                     errors;

        function new();
            coef[0] = COEF_ONE_I;
            for (int i = 1; i < NUM_COEFS; i++) coef[i] = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                x1[c] = 0;
                x2[c] = 0;
                y1[c] = 0;
                y2[c] = 0;
            end
            primed = 1'b0;
            errors = 0;
        endfunction

        // indexes past the last coefficient are dropped by the block
        function void write_coef(int idx, logic [COEF_BITS-1:0] v);
            if (idx < NUM_COEFS) coef[idx] = longint'($signed(v));
        endfunction

        // Run one accepted input beat through the filter and queue its output.
        function void filter_input(logic [DATA_BITS-1:0] d);
            logic [DATA_BITS-1:0] res;
            sample_t              s;
            longint               x;
            longint               acc;
            longint               q;
            res = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                s = d[c*SAMPLE_BITS +: SAMPLE_BITS];
                x = s;
                // first beat after reset fills every history slot with the sample
                if (!primed) begin
                    x1[c] = x;
                    x2[c] = x;
                    y1[c] = x;
                    y2[c] = x;
                end
                acc = coef[0] * x + coef[1] * x1[c] + coef[2] * x2[c]
                    - coef[3] * y1[c] - coef[4] * y2[c];
                // round half up, then floor
                q = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
                if (q > SAMPLE_MAX_I) q = SAMPLE_MAX_I;
                else if (q < SAMPLE_MIN_I) q = SAMPLE_MIN_I;
                x2[c] = x1[c];
                x1[c] = x;
                y2[c] = y1[c];
                y1[c] = q;
                res[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(q);
            end
            primed = 1'b1;
            filtered_q.push_back(res);
        endfunction

        // Compare one accepted output beat with the oldest queued one.
        function void match_output(logic [DATA_BITS-1:0] d);
            logic [DATA_BITS-1:0] want;
            sample_t              w;
            sample_t              g;
            if (filtered_q.size() == 0) begin
                $error("output beat with nothing queued: %h", d);
                errors++;
                return;
            end
            want = filtered_q.pop_front();
            for (int c = 0; c < CHANNELS; c++) begin
                w = want[c*SAMPLE_BITS +: SAMPLE_BITS];
                g = d[c*SAMPLE_BITS +: SAMPLE_BITS];
                if (g !== w) begin
                    $error("filtered_%0d: expected %0d, actual %0d", c, w, g);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]    cfg_index;
    logic [COEF_BITS-1:0]       cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [DATA_BITS-1:0]       s_tdata;   // sample_0 .. sample_5
    logic                       m_tvalid;
    logic                       m_tready;
    logic [DATA_BITS-1:0]       m_tdata;   // filtered_0 .. filtered_5

    filter_tracker  tracker;
    bit             calm;      // set in the last phase: no idling on either side

    biquad_lowpass_multichannel u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a beat never shows up.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [DATA_BITS-1:0] beat6(int a, int b, int c, int d, int e, int f);
        return {sample_t'(f), sample_t'(e), sample_t'(d), sample_t'(c), sample_t'(b),
                sample_t'(a)};
    endfunction

    // Mostly full-range noise, with a share of extremes and values near zero.
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: begin
                return sample_t'(SAMPLE_MAX_I);
            end
            1: begin
                return sample_t'(SAMPLE_MIN_I);
            end
            2: begin
                return sample_t'(int'($urandom_range(0, 32)) - 16);
            end
            default: begin
                return sample_t'($urandom());
            end
        endcase
    endfunction

    function automatic logic [DATA_BITS-1:0] random_beat();
        logic [DATA_BITS-1:0] d;
        d = '0;
        for (int c = 0; c < CHANNELS; c++) d[c*SAMPLE_BITS +: SAMPLE_BITS] = rand_sample();
        return d;
    endfunction

    // Offer one beat and hold it until the block takes it. Valid stays high on
    // return so back-to-back beats need no extra assignment.
    task automatic send_beat(logic [DATA_BITS-1:0] d);
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.filter_input(d);
    endtask

    task automatic sender_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Stop offering and wait until every queued output has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_BITS'(idx);
        cfg_data  <= COEF_BITS'(v);
        @(posedge aclk);
        tracker.write_coef(idx, COEF_BITS'(v));
    endtask

    task automatic set_coefs(int b0, int b1, int b2, int a1, int a2);
        write_reg(IDX_B0, b0);
        write_reg(IDX_B1, b1);
        write_reg(IDX_B2, b2);
        write_reg(IDX_A1, a1);
        write_reg(IDX_A2, a2);
        cfg_wr_en <= 1'b0;
    endtask

    // Hit every index past the coefficient bank; the block must drop these.
    task automatic write_unused_regs();
        for (int idx = NUM_COEFS; idx < 2 ** CFG_IDX_BITS; idx++)
            write_reg(idx, int'($urandom_range(0, 2 ** COEF_BITS - 1)));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int rand_coef_wide();
        return int'($urandom_range(0, 2 ** COEF_BITS - 1)) + COEF_MIN_I;
    endfunction

    function automatic int rand_coef_mild();
        return int'($urandom_range(0, COEF_ONE_I)) - COEF_ONE_I / 2;
    endfunction

    task automatic load_set(coef_set_e kind);
        case (kind)
            SET_IDENTITY: begin
                set_coefs(COEF_ONE_I, 0, 0, 0, 0);
            end
            SET_BUTTER: begin
                // fc near fs/10
                set_coefs(4426, 8852, 4426, -74908, 27054);
            end
            SET_RANDOM_WIDE: begin
                set_coefs(rand_coef_wide(), rand_coef_wide(), rand_coef_wide(),
                          rand_coef_wide(), rand_coef_wide());
            end
            SET_RANDOM_MILD: begin
                set_coefs(rand_coef_mild(), rand_coef_mild(), rand_coef_mild(),
                          rand_coef_mild(), rand_coef_mild());
            end
            SET_ALL_MAX: begin
                set_coefs(COEF_MAX_I, COEF_MAX_I, COEF_MAX_I, COEF_MAX_I, COEF_MAX_I);
            end
            SET_ALL_MIN: begin
                set_coefs(COEF_MIN_I, COEF_MIN_I, COEF_MIN_I, COEF_MIN_I, COEF_MIN_I);
            end
            default: begin
                set_coefs(COEF_MAX_I, COEF_MIN_I, COEF_MAX_I, COEF_MIN_I, COEF_MAX_I);
            end
        endcase
        // let the write enable drop before the next burst of writes
        @(posedge aclk);
        write_unused_regs();
    endtask

    // Output side: accept beats, idle in random bursts, and stall once for a
    // long stretch so the pipeline backs up into the input.
    initial begin : output_sink
        int  left;
        int  seen;
        bit  stalled_once;
        left         = 0;
        seen         = 0;
        stalled_once = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                tracker.match_output(m_tdata);
                seen++;
            end
            if (!stalled_once && seen == STALL_AT_BEAT) begin
                stalled_once = 1'b1;
                m_tready <= 1'b0;
                left = STALL_CYCLES;
            end else if (left > 0) begin
                left--;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready <= 1'b1;
                left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 30) - 1;
            end
        end
    end

    initial begin : stimulus
        coef_set_e plan[NUM_PHASES];
        bit        gaps_on;
        plan = '{SET_BUTTER, SET_RANDOM_MILD, SET_RANDOM_WIDE, SET_ALL_MAX,
                 SET_MIXED, SET_ALL_MIN, SET_IDENTITY, SET_BUTTER};
        tracker = new();
        calm    = 1'b0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Reset coefficients pass the input through; the first beat also primes
        // the history, so extremes must come out unchanged.
        send_beat(beat6(SAMPLE_MAX_I, SAMPLE_MIN_I, 0, -1, 1, 'h123456));
        send_beat(beat6(SAMPLE_MIN_I, SAMPLE_MAX_I, -1, 0, 'h555555, -'h555556));
        send_beat(random_beat());
        send_beat(beat6(0, SAMPLE_MAX_I, SAMPLE_MIN_I, 2, -2, 0));
        drain();

        // b0 = 0.5 on odd samples lands exactly on half an LSB: ties go up.
        set_coefs(COEF_ONE_I / 2, 0, 0, 0, 0);
        send_beat(beat6(1, -1, 3, -3, SAMPLE_MAX_I, SAMPLE_MIN_I));
        send_beat(beat6(-5, 5, 7, -7, 0, -1));
        drain();

        // Largest gains drive both saturation bounds.
        set_coefs(COEF_MAX_I, COEF_MAX_I, COEF_MAX_I, COEF_MAX_I, COEF_MAX_I);
        send_beat(beat6(SAMPLE_MAX_I, SAMPLE_MIN_I, 1, -1, 0, SAMPLE_MAX_I));
        send_beat(beat6(SAMPLE_MIN_I, SAMPLE_MAX_I, 0, 0, -1, 1));
        send_beat(random_beat());
        drain();

        set_coefs(COEF_MIN_I, COEF_MIN_I, COEF_MIN_I, COEF_MIN_I, COEF_MIN_I);
        send_beat(beat6(SAMPLE_MAX_I, SAMPLE_MIN_I, 1, -1, 0, SAMPLE_MIN_I));
        send_beat(beat6(SAMPLE_MIN_I, SAMPLE_MAX_I, 0, 0, -1, 1));
        send_beat(random_beat());
        drain();

        // Writes past the coefficient bank must leave the settings alone.
        write_unused_regs();
        send_beat(beat6(1000, -1000, SAMPLE_MAX_I, SAMPLE_MIN_I, 7, -7));
        send_beat(random_beat());
        drain();

        load_set(SET_BUTTER);
        send_beat(beat6(SAMPLE_MAX_I, SAMPLE_MAX_I, SAMPLE_MIN_I, 0, 100, -100));
        send_beat(beat6(SAMPLE_MAX_I, SAMPLE_MIN_I, SAMPLE_MIN_I, 0, 100, -100));
        send_beat(random_beat());
        drain();

        // Random phases, one coefficient set each, with the input history
        // carried across settings.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_set(plan[ph]);
            calm    = (ph == NUM_PHASES - 1);
            gaps_on = !calm && (ph % 3 != 2);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (gaps_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
                send_beat(random_beat());
            end
            drain();
        end

        repeat (2 * LATENCY) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### biquad_lowpass_multichannel.f
hdl/bqlp_pkg.sv
hdl/biquad_lowpass_multichannel.sv
test/tb_biquad_lowpass_multichannel.sv
